### rtl/core/fppd_pkg.sv
// Package for the FIFO page pool directory: sizes, operation codes and the
// request, response and engine status types. Depends on nothing.
package fppd_pkg;

  // Number of pages the pool holds.
  localparam int POOL_DEPTH = 4;

  // Slot index width and fill count width (the count must reach POOL_DEPTH).
  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  localparam int TABLE_W = 8;
  localparam int PAGE_W  = 16;
  localparam int KEY_W   = TABLE_W + PAGE_W;
  localparam int OCC_W   = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [TABLE_W-1:0] table_id;
    logic [PAGE_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    logic               found;
    logic               evicted_valid;
    logic [TABLE_W-1:0] evicted_table;
    logic [PAGE_W-1:0]  evicted_page;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

endpackage

### rtl/core/fppd_engine.sv
// Key store and sequencer of the FIFO page pool directory. One key comparator
// walks the slots, then the slots are moved one per cycle. Uses fppd_pkg.
module fppd_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fppd_pkg::req_t      req,
  input  logic                take,
  output fppd_pkg::eng_status_t status,
  output fppd_pkg::rsp_t      rsp
);
  import fppd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_APPEND = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  logic [KEY_W-1:0] key_store [POOL_DEPTH];

  state_t           state;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] fill;
  logic             op;
  logic [KEY_W-1:0] key;
  logic             found;
  logic             ev_valid;
  logic [KEY_W-1:0] ev_key;
  logic             append_pending;

  logic [KEY_W-1:0] cur;
  logic [CNT_W-1:0] idx_prev;
  logic             in_range;
  logic             match;

  assign cur      = key_store[idx[IDX_W-1:0]];
  assign idx_prev = idx - CNT_W'(1);
  assign in_range = (idx < fill);
  assign match    = (cur == key);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (in_range) begin
            if (match) begin
              state <= (op == OP_REMOVE) ? ST_SHIFT : ST_DONE;
            end
          end else if (op == OP_LOOKUP) begin
            state <= (fill == CNT_W'(POOL_DEPTH)) ? ST_SHIFT : ST_APPEND;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SHIFT: begin
          if (!in_range) begin
            fill  <= fill - CNT_W'(1);
            state <= append_pending ? ST_APPEND : ST_DONE;
          end
        end
        ST_APPEND: begin
          fill  <= fill + CNT_W'(1);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers and the key store.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          op             <= req.operation;
          key            <= {req.table_id, req.page_index};
          idx            <= '0;
          found          <= 1'b0;
          ev_valid       <= 1'b0;
          append_pending <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          // Slot 0 is the oldest entry and the eviction victim.
          if (idx == '0) begin
            ev_key <= cur;
          end
          if (match) begin
            found <= 1'b1;
          end
          idx <= idx + CNT_W'(1);
        end else if (op == OP_LOOKUP && fill == CNT_W'(POOL_DEPTH)) begin
          ev_valid       <= 1'b1;
          append_pending <= 1'b1;
          idx            <= CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        if (in_range) begin
          key_store[idx_prev[IDX_W-1:0]] <= cur;
          idx <= idx + CNT_W'(1);
        end
      end
      ST_APPEND: begin
        key_store[fill[IDX_W-1:0]] <= key;
      end
      default: begin
      end
    endcase
  end

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);

  assign rsp.found         = found;
  assign rsp.evicted_valid = ev_valid;
  assign rsp.evicted_table = ev_valid ? ev_key[KEY_W-1:PAGE_W] : '0;
  assign rsp.evicted_page  = ev_valid ? ev_key[PAGE_W-1:0] : '0;
  assign rsp.occupancy     = OCC_W'(fill);

endmodule

### rtl/core/fifo_page_pool_directory.sv
// Top level of the FIFO page pool directory: request handshake, result
// register and the sequenced engine. Uses fppd_pkg and fppd_engine.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   fppd_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall   fppd_pkg::rsp_t
//
// A single key comparator visits the held slots one per cycle, and the slots
// behind a removed or evicted entry then move forward one per cycle, so the
// count of held pages and the position of a match set the time from one
// request transfer to the next.
// Reset (synchronous, active high) empties the pool and drops any result.
// req_stall is high while a request is in work; a stalled result waits in
// the result register while the next request is already taken.
module fifo_page_pool_directory (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  fppd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output fppd_pkg::rsp_t rsp
);
  import fppd_pkg::*;

  eng_status_t eng_status;
  rsp_t        eng_rsp;
  logic        start;
  logic        take;

  // The engine registers the request itself when it starts.
  assign req_stall = !eng_status.idle;
  assign start     = req_valid && eng_status.idle;

  // A finished result moves to the result register once that register is
  // empty or its transfer completes in this cycle.
  assign take = eng_status.done && (!rsp_valid || !rsp_stall);

  fppd_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .take   (take),
    .status (eng_status),
    .rsp    (eng_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= eng_rsp;
    end
  end

`ifndef NO_ASSERTIONS
  // An eviction only ever follows a lookup that missed.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.evicted_valid && rsp.found))
    else $error("eviction reported together with a hit");

  // Without an eviction the victim fields read as zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.evicted_valid) |->
      (rsp.evicted_table == '0 && rsp.evicted_page == '0))
    else $error("victim fields set without an eviction");

  // A request taken in puts the engine to work in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("engine idle right after a request transfer");

  // A finished result that cannot move on is held, not lost.
  a_done_held: assert property (@(posedge clk) disable iff (rst)
    (eng_status.done && !take) |=> eng_status.done)
    else $error("finished result dropped while the result register was full");
`endif

endmodule

### dv/fifo_page_pool_directory_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fifo_page_pool_directory: random and directed page
// requests, a built-in pool predictor and an in-order result checker.
// Depends on fppd_pkg and the fifo_page_pool_directory RTL.
module fifo_page_pool_directory_tb;
  import fppd_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  // Neither side idles while the transfer count is in this window.
  localparam int STEADY_LO    = 220;
  localparam int STEADY_HI    = 320;
  // The receiver holds off once, after this many results, for this many cycles.
  localparam int HOLDOFF_AT   = 120;
  localparam int HOLDOFF_LEN  = 80;
  // The run limit in ns; it is far above the time that one request takes.
  localparam int TIMEOUT_NS   = 2000000;
  localparam int HOT_KEYS     = 6;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  fifo_page_pool_directory u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and results predicted but not yet seen.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   total_reqs;
  int   sent_count;
  int   mismatches;

  // Predicted pool contents: slot 0 holds the oldest page.
  logic [KEY_W-1:0] pool_keys [POOL_DEPTH];
  int               pool_fill;

  // What the run exercised, for the closing summary.
  int lookup_hits, lookup_fills, evictions, removes_hit, removes_missed;

  function automatic void queue_req(logic op, logic [TABLE_W-1:0] tab,
                                    logic [PAGE_W-1:0] pg);
    req_t r;
    r.operation  = op;
    r.table_id   = tab;
    r.page_index = pg;
    pending_reqs = {pending_reqs, r};
  endfunction

  // Deletes one slot and closes the gap so the insertion order is kept.
  function automatic void drop_pool_slot(int slot);
    for (int i = slot + 1; i < pool_fill; i++) pool_keys[i-1] = pool_keys[i];
    pool_fill--;
  endfunction

  // Applies one request to the predicted pool and returns the result it must give.
  function automatic rsp_t pool_access(req_t r);
    logic [KEY_W-1:0] key;
    int               hit_slot;
    rsp_t             res;
    key      = {r.table_id, r.page_index};
    hit_slot = -1;
    for (int i = 0; i < pool_fill; i++) begin
      if (hit_slot < 0 && pool_keys[i] == key) hit_slot = i;
    end
    res       = '0;
    res.found = (hit_slot >= 0);
    if (r.operation == OP_LOOKUP) begin
      if (hit_slot >= 0) begin
        lookup_hits++;
      end else begin
        // A miss on a full pool pushes out the oldest page first.
        if (pool_fill == POOL_DEPTH) begin
          res.evicted_valid = 1'b1;
          res.evicted_table = pool_keys[0][KEY_W-1:PAGE_W];
          res.evicted_page  = pool_keys[0][PAGE_W-1:0];
          drop_pool_slot(0);
          evictions++;
        end
        pool_keys[pool_fill] = key;
        pool_fill++;
        lookup_fills++;
      end
    end else if (hit_slot >= 0) begin
      drop_pool_slot(hit_slot);
      removes_hit++;
    end else begin
      removes_missed++;
    end
    res.occupancy = pool_fill[OCC_W-1:0];
    return res;
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Sender. A request is predicted at the edge where its transfer happens; the
  // next one is offered only once the current one is gone, so a stalled
  // payload never changes.
  always @(posedge clk) begin
    logic idle_now;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps = {expected_rsps, pool_access(req)};
        sent_count++;
      end
      if (!req_valid || !req_stall) begin
        idle_now = (sent_count < STEADY_LO || sent_count >= STEADY_HI) &&
                   ($urandom_range(99) < 21);
        if (pending_reqs.size() > 0 && !idle_now) begin
          req       <= pending_reqs[0];
          req_valid <= 1'b1;
          pending_reqs.delete(0);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. Apart from random stalls it holds off once for a long
  // stretch, so the result register stays full and the block stalls its input
  // while the sender keeps offering.
  int  drained;
  int  holdoff_left;
  bit  holdoff_done;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) drained++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_stall <= 1'b1;
      end else if (!holdoff_done && drained >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN - 1;
        rsp_stall    <= 1'b1;
      end else if (drained >= STEADY_LO && drained < STEADY_HI) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 21);
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: %p", rsp));
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        if (rsp.found !== want.found || rsp.evicted_valid !== want.evicted_valid ||
            rsp.evicted_table !== want.evicted_table ||
            rsp.evicted_page !== want.evicted_page || rsp.occupancy !== want.occupancy)
        begin
          report_mismatch($sformatf({"expected found=%0b ev=%0b tab=%h pg=%h occ=%0d,",
                                     " got found=%0b ev=%0b tab=%h pg=%h occ=%0d"},
                                    want.found, want.evicted_valid, want.evicted_table,
                                    want.evicted_page, want.occupancy, rsp.found,
                                    rsp.evicted_valid, rsp.evicted_table,
                                    rsp.evicted_page, rsp.occupancy));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [KEY_W-1:0] hot_keys [HOT_KEYS];
    logic [KEY_W-1:0] key;

    // Directed part: removal from an empty pool, extreme keys, filling up, hits
    // on a full pool, evictions, removal of oldest, middle and newest pages,
    // a repeated removal and keys that differ only in one field.
    queue_req(OP_REMOVE, 8'h00, 16'h0000);
    queue_req(OP_LOOKUP, 8'h00, 16'h0000);
    queue_req(OP_LOOKUP, 8'hFF, 16'hFFFF);
    queue_req(OP_LOOKUP, 8'h00, 16'h0000);
    queue_req(OP_LOOKUP, 8'h12, 16'h3456);
    queue_req(OP_LOOKUP, 8'hA5, 16'h5AA5);
    queue_req(OP_LOOKUP, 8'hFF, 16'hFFFF);
    queue_req(OP_LOOKUP, 8'h5A, 16'hA55A);
    queue_req(OP_LOOKUP, 8'h00, 16'h0000);
    queue_req(OP_REMOVE, 8'h99, 16'h9999);
    queue_req(OP_REMOVE, 8'h5A, 16'hA55A);
    queue_req(OP_REMOVE, 8'h12, 16'h3456);
    queue_req(OP_REMOVE, 8'h00, 16'h0000);
    queue_req(OP_REMOVE, 8'h00, 16'h0000);
    queue_req(OP_LOOKUP, 8'hA5, 16'h0000);
    queue_req(OP_LOOKUP, 8'h00, 16'h5AA5);
    queue_req(OP_LOOKUP, 8'hA5, 16'h5AA5);
    queue_req(OP_LOOKUP, 8'hFF, 16'h0000);
    queue_req(OP_LOOKUP, 8'h00, 16'hFFFF);
    queue_req(OP_REMOVE, 8'hA5, 16'h5AA5);
    queue_req(OP_REMOVE, 8'hA5, 16'h0000);
    queue_req(OP_REMOVE, 8'h00, 16'h5AA5);
    queue_req(OP_REMOVE, 8'hFF, 16'h0000);
    queue_req(OP_REMOVE, 8'h00, 16'hFFFF);
    queue_req(OP_LOOKUP, 8'hFF, 16'hFFFF);

    // Random part: most keys come from a small working set a little larger than
    // the pool, so hits, evictions and successful removals are all common. The
    // set drifts now and then, and some keys are fully random.
    foreach (hot_keys[i]) hot_keys[i] = KEY_W'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 5) hot_keys[$urandom_range(HOT_KEYS-1)] = KEY_W'($urandom);
      if ($urandom_range(99) < 85) key = hot_keys[$urandom_range(HOT_KEYS-1)];
      else key = KEY_W'($urandom);
      queue_req(($urandom_range(99) < 30) ? OP_REMOVE : OP_LOOKUP,
                key[KEY_W-1:PAGE_W], key[PAGE_W-1:0]);
    end
    total_reqs = pending_reqs.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (sent_count == total_reqs);
    wait (expected_rsps.size() == 0);
    // Let a stray extra result show up before closing.
    repeat (4 * POOL_DEPTH + 10) @(posedge clk);

    $display("Ran %0d request transfers: %0d lookup hits, %0d inserts, %0d evictions,",
             total_reqs, lookup_hits, lookup_fills, evictions);
    $display("%0d removes of held pages, %0d removes of absent pages, %0d mismatches.",
             removes_hit, removes_missed, mismatches);
    if (mismatches == 0) begin
      $display("fifo_page_pool_directory regression: pass");
    end else begin
      $display("fifo_page_pool_directory regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d of %0d requests sent and %0d results outstanding.",
             sent_count, total_reqs, expected_rsps.size());
    $display("fifo_page_pool_directory regression: fail");
    $finish;
  end

endmodule
